// ===== sv/assert_macros.svh =====
// Assertion macros shared by the calendar date adder RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/cda_pkg.sv =====
// Package for the calendar date adder: states, control structs, month table.
// Depends on nothing.
`default_nettype none

package cda_pkg;

  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
  localparam logic [15:0] YEAR_RESET    = 16'd2000;

  // year / 25 == (year * LEAP_RECIP) >> LEAP_SHIFT for every 16-bit year
  localparam logic [16:0] LEAP_RECIP = 17'd83887;
  localparam int          LEAP_SHIFT = 21;

  localparam logic [4:0] MONTH_DAYS [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_MUL,
    ST_LEAP_CHK,
    ST_CLAMP,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;      // accept the input transfer
    logic leap_upd;  // latch leap flag from the leap unit
    logic clamp;     // clamp day into 1..month length
    logic step;      // one walk step (only acts when day > length)
    logic done;      // result strobe next cycle
  } ctl_t;

  typedef struct packed {
    logic gt;    // working day exceeds month length
    logic wrap;  // current month is December
    logic op;    // latched operation, 1 = add
  } sts_t;

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < MONTH_JAN) r = MONTH_JAN;
    else if (m > MONTH_DEC) r = MONTH_DEC;
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] mc;
    logic [4:0] len;
    mc = clamp_month(m);
    if (mc == MONTH_FEB && leap) len = FEB_LEAP_DAYS;
    else len = MONTH_DAYS[mc];
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cda_leap_unit.sv =====
// Leap-year evaluator: registered reciprocal multiply, then combinational check.
// Depends on cda_pkg.
`default_nettype none

module cda_leap_unit
  import cda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [15:0] year,
  output logic             leap
);

  logic [32:0] prod;
  logic [11:0] quot_r;
  logic [15:0] quot_x25;
  logic        div25;

  assign prod = {17'd0, year} * {16'd0, LEAP_RECIP};

  always_ff @(posedge clk) begin
    quot_r <= prod[LEAP_SHIFT+11:LEAP_SHIFT];
  end

  // q*25 = q*16 + q*8 + q
  assign quot_x25 = {quot_r, 4'b0000} + {1'b0, quot_r, 3'b000} + {4'b0000, quot_r};
  assign div25    = (quot_x25 == year);

  // div by 4, and not by 100 unless by 400
  assign leap = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

`default_nettype wire

// ===== sv/cda_fsm.sv =====
// Sequencer for the calendar date adder: accept, leap update, clamp, walk.
// Depends on cda_pkg.
`default_nettype none

module cda_fsm
  import cda_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_op,
  input  wire sts_t sts,
  output logic      busy,
  output ctl_t      ctl
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_op ? ST_WALK : ST_LEAP_MUL;
      end
      ST_LEAP_MUL: state_nxt = ST_LEAP_CHK;
      ST_LEAP_CHK: state_nxt = sts.op ? ST_WALK : ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_IDLE;
      ST_WALK: begin
        if (!sts.gt) state_nxt = ST_IDLE;
        else if (sts.wrap) state_nxt = ST_LEAP_MUL;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = accept;
      end
      ST_LEAP_MUL: ;
      ST_LEAP_CHK: ctl.leap_upd = 1'b1;
      ST_CLAMP: begin
        ctl.clamp = 1'b1;
        ctl.done  = 1'b1;
      end
      ST_WALK: begin
        ctl.step = 1'b1;
        ctl.done = !sts.gt;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/calendar_date_adder.sv =====
// Top level of the calendar date adder: date registers and the walk datapath.
// Depends on cda_pkg, cda_leap_unit, cda_fsm and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Holds one Gregorian date (reset 1 Jan 2000). A transfer is taken at a
// rising edge with start high and busy low. Set (in_operation 0) loads the
// date, clamping month to 1..12 and day to 1..month length; add (1) moves
// the held date forward by in_day_count days. Every transfer gives one
// result, shown for exactly one cycle with out_valid high; there is no
// backpressure, so capture it on that cycle. While idle, the held date stays
// on the out_ ports. A set runs the leap check of the new year (registered
// multiply, then check), then the day clamp. An add subtracts one month
// length per cycle through a single compare/subtract unit, pausing after
// each New Year while the leap unit re-evaluates. busy is low during the
// strobe cycle, so the next transfer may be taken then.
module calendar_date_adder
  import cda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_set_day,
  input  wire logic [3:0]  in_set_month,
  input  wire logic [15:0] in_set_year,
  input  wire logic [15:0] in_day_count,
  output logic             out_valid,
  output logic [4:0]       out_day,
  output logic [3:0]       out_month,
  output logic [15:0]      out_year,
  output logic             out_is_leap
);

  // Working day is wide enough for held day plus the largest count.
  logic [16:0] day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;
  logic        leap_r, leap_nxt;
  logic        op_r, op_nxt;
  logic        valid_r;

  logic [4:0]  len;
  logic [16:0] len_w;
  logic        leap_calc;
  logic        date_ok;
  ctl_t        ctl;
  sts_t        sts;

  cda_leap_unit u_leap (
    .clk  (clk),
    .year (year_r),
    .leap (leap_calc)
  );

  cda_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_operation),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Shared compare: month length of the held month under the held leap flag.
  assign len   = month_len(month_r, leap_r);
  assign len_w = {12'd0, len};

  assign sts.gt   = (day_r > len_w);
  assign sts.wrap = (month_r == MONTH_DEC);
  assign sts.op   = op_r;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    leap_nxt  = leap_r;
    op_nxt    = op_r;
    if (ctl.load) begin
      op_nxt = in_operation;
      if (in_operation) begin
        day_nxt = day_r + {1'b0, in_day_count};
      end else begin
        day_nxt   = {11'd0, in_set_day};
        month_nxt = clamp_month(in_set_month);
        year_nxt  = in_set_year;
      end
    end
    if (ctl.leap_upd) leap_nxt = leap_calc;
    if (ctl.clamp) begin
      if (day_r == 17'd0) day_nxt = 17'd1;
      else if (sts.gt) day_nxt = len_w;
    end
    if (ctl.step && sts.gt) begin
      day_nxt = day_r - len_w;
      if (sts.wrap) begin
        month_nxt = MONTH_JAN;
        year_nxt  = year_r + 16'd1;  // wraps modulo 65536
      end else begin
        month_nxt = month_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= 17'd1;
      month_r <= MONTH_JAN;
      year_r  <= YEAR_RESET;
      leap_r  <= 1'b1;
      op_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      leap_r  <= leap_nxt;
      op_r    <= op_nxt;
      valid_r <= ctl.done;
    end
  end

  assign out_valid   = valid_r;
  assign out_day     = day_r[4:0];
  assign out_month   = month_r;
  assign out_year    = year_r;
  assign out_is_leap = leap_r;

  assign date_ok = (out_day != 5'd0) && (out_month != 4'd0) && (out_month <= MONTH_DEC) &&
                   (day_r[16:5] == 12'd0);

  // A strobed result always has a day in 1..31 and a month in 1..12.
  `ASSERT_CLK(a_result_legal, out_valid |-> date_ok, "result date out of range")
  // An accepted transfer always makes the block busy.
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted transfer did not raise busy")
  // The strobe cycle is idle.
  `ASSERT_CLK(a_strobe_idle, out_valid |-> !busy, "block busy during result strobe")
  // With no new transfer in the strobe cycle, the held date stays put after it.
  `ASSERT_CLK(a_hold_date, (out_valid && !start) |=> ($stable(day_r) && $stable(month_r)), "date moved after result strobe")

endmodule

`default_nettype wire

// ===== verif/calendar_date_adder_test.sv =====
// Self-checking test of calendar_date_adder: directed and random set/add transfers.
// Holds its own date predictor and result scoreboard; needs only the block's RTL.
`default_nettype none

package cda_test_pkg;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_ADD = 1'b1;

  typedef struct packed {
    logic        op;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] count;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        leap;
  } date_t;

  function automatic logic gregorian_leap(logic [15:0] y);
    int unsigned yi;
    yi = y;
    if (yi % 4 != 0) return 1'b0;
    if (yi % 100 != 0) return 1'b1;
    return (yi % 400) == 0;
  endfunction

  // month is already 1..12 here
  function automatic int days_in_month(logic [3:0] m, logic [15:0] y);
    case (m)
      4'd2: return gregorian_leap(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  class date_scoreboard;
    date_t held;
    date_t pending_dates[$];
    int    errors;

    function new();
      held   = '{day: 5'd1, month: 4'd1, year: 16'd2000, leap: 1'b1};
      errors = 0;
    endfunction

    // Advance the predicted date for one accepted transfer.
    function void note_transfer(date_cmd_t c);
      int          d;
      int          len;
      logic [3:0]  m;
      logic [15:0] y;
      if (c.op == OP_SET) begin
        m = c.month;
        if (m < 4'd1) m = 4'd1;
        else if (m > 4'd12) m = 4'd12;
        y = c.year;
        len = days_in_month(m, y);
        d = c.day;
        if (d < 1) d = 1;
        else if (d > len) d = len;
      end else begin
        d = held.day + c.count;
        m = held.month;
        y = held.year;
        len = days_in_month(m, y);
        while (d > len) begin
          d -= len;
          if (m == 4'd12) begin
            m = 4'd1;
            y = y + 16'd1;
          end else begin
            m = m + 4'd1;
          end
          len = days_in_month(m, y);
        end
      end
      held.day   = d[4:0];
      held.month = m;
      held.year  = y;
      held.leap  = gregorian_leap(y);
      pending_dates.push_back(held);
    endfunction

    function void check_result(date_t got);
      date_t want;
      if (pending_dates.size() == 0) begin
        $error("unexpected result %0d/%0d/%0d leap %0b",
               got.day, got.month, got.year, got.leap);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      if (got.day != want.day) begin
        $error("out_day: expected %0d, got %0d", want.day, got.day);
        errors++;
      end
      if (got.month != want.month) begin
        $error("out_month: expected %0d, got %0d", want.month, got.month);
        errors++;
      end
      if (got.year != want.year) begin
        $error("out_year: expected %0d, got %0d", want.year, got.year);
        errors++;
      end
      if (got.leap != want.leap) begin
        $error("out_is_leap: expected %0b, got %0b", want.leap, got.leap);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_dates.size();
    endfunction
  endclass

endpackage

module calendar_date_adder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_test_pkg::*;

  // A full 65535-day add is the longest walk; allow plenty of margin.
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [5:0]  in_set_day;
  logic [3:0]  in_set_month;
  logic [15:0] in_set_year;
  logic [15:0] in_day_count;
  logic        out_valid;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [15:0] out_year;
  logic        out_is_leap;

  date_scoreboard dates = new();
  int unsigned    quiet_cycles;
  bit             no_gaps;

  calendar_date_adder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_set_day   (in_set_day),
    .in_set_month (in_set_month),
    .in_set_year  (in_set_year),
    .in_day_count (in_day_count),
    .out_valid    (out_valid),
    .out_day      (out_day),
    .out_month    (out_month),
    .out_year     (out_year),
    .out_is_leap  (out_is_leap)
  );

  always #1 clk = ~clk;

  // Monitor. Values read here are the ones settled before this edge, so the
  // input transfer and the result strobe are seen exactly as the block sees
  // them. The result is checked before the new transfer is noted: a strobe
  // and the next accept can share an edge, and the strobe belongs to the
  // older transfer anyway since the queue is in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        dates.check_result('{day: out_day, month: out_month,
                             year: out_year, leap: out_is_leap});
      end
      if (start && !busy) begin
        dates.note_transfer('{op: in_operation, day: in_set_day, month: in_set_month,
                              year: in_set_year, count: in_day_count});
      end
    end
  end

  // Watchdog: cycles with neither an input transfer nor a result.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL calendar_date_adder");
      $finish;
    end
  end

  function automatic date_cmd_t make_cmd(logic op, int day, int month, int year, int count);
    date_cmd_t c;
    c.op    = op;
    c.day   = day[5:0];
    c.month = month[3:0];
    c.year  = year[15:0];
    c.count = count[15:0];
    return c;
  endfunction

  // Present one command and hold it until the block takes it. start stays
  // high across back-to-back transfers; a gap lowers it only in the step
  // right after the previous accept.
  task automatic send_cmd(date_cmd_t c);
    if (!no_gaps && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= c.op;
    in_set_day   <= c.day;
    in_set_month <= c.month;
    in_set_year  <= c.year;
    in_day_count <= c.count;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending until every predicted date has come back.
  task automatic drain();
    start <= 1'b0;
    while (dates.outstanding() != 0) @(posedge clk);
  endtask

  // Random command. Sets favor month ends, century years and years near the
  // 16-bit wrap; adds are mostly short so the long walks stay affordable.
  function automatic date_cmd_t random_cmd();
    date_cmd_t c;
    int        pick;
    c.op    = ($urandom_range(99) < 30) ? OP_SET : OP_ADD;
    c.month = 4'($urandom_range(15));
    c.day   = ($urandom_range(1) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(26, 32));
    case ($urandom_range(3))
      0: c.year = 16'($urandom);
      1: c.year = 16'($urandom_range(1580, 2420));
      2: c.year = 16'($urandom_range(65400, 65535));
      default: c.year = 16'($urandom_range(655) * 100);
    endcase
    pick = $urandom_range(99);
    if (pick < 55) c.count = 16'($urandom_range(40));
    else if (pick < 80) c.count = 16'($urandom_range(400));
    else if (pick < 92) c.count = 16'($urandom_range(3000));
    else if (pick < 99) c.count = 16'($urandom);
    else c.count = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
    return c;
  endfunction

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_SET;
    in_set_day   <= '0;
    in_set_month <= '0;
    in_set_year  <= '0;
    in_day_count <= '0;
    no_gaps       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset date, clamps at both ends, leap rule corners,
    // year wrap, zero and full day counts, ignored fields.
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 0));             // reset date unchanged
    send_cmd(make_cmd(OP_ADD, 63, 15, 65535, 1));       // set fields ignored on add
    send_cmd(make_cmd(OP_SET, 0, 0, 0, 65535));         // day/month 0 -> 1, year 0 leap
    send_cmd(make_cmd(OP_SET, 63, 15, 65535, 0));       // month 15 -> 12, day -> 31
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 1));             // 31 Dec 65535 -> 1 Jan 0
    send_cmd(make_cmd(OP_SET, 29, 2, 2000, 0));         // divisible by 400: leap
    send_cmd(make_cmd(OP_SET, 30, 2, 1900, 0));         // century: clamp to 28
    send_cmd(make_cmd(OP_SET, 31, 2, 2004, 0));         // plain leap: 29
    send_cmd(make_cmd(OP_SET, 29, 2, 2001, 0));         // common year: 28
    send_cmd(make_cmd(OP_SET, 31, 4, 2023, 0));         // 30-day month clamp
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_SET, 28, 2, 2024, 0));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 1));             // into 29 Feb
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 1));             // into 1 Mar
    send_cmd(make_cmd(OP_SET, 31, 12, 2099, 0));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 65535));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 65535));
    send_cmd(make_cmd(OP_SET, 1, 13, 1600, 0));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 366));
    send_cmd(make_cmd(OP_SET, 15, 7, 65500, 0));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 65535));         // walks across the year wrap
    send_cmd(make_cmd(OP_SET, 31, 1, 65535, 0));
    send_cmd(make_cmd(OP_ADD, 0, 0, 0, 396));           // across 29 Feb of year 0 into 2 Mar
    drain();

    // Random part: a stretch without gaps in the middle, and one pause
    // until the block has returned everything.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps = (i >= 600 && i < 1000);
      if (i == 1300) drain();
      send_cmd(random_cmd());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (dates.errors == 0 && dates.outstanding() == 0) begin
      $display("PASS calendar_date_adder");
    end else begin
      $display("FAIL calendar_date_adder");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/cda_pkg.sv
sv/cda_leap_unit.sv
sv/cda_fsm.sv
sv/calendar_date_adder.sv
verif/calendar_date_adder_test.sv
